>>> rtl/rgbds_pkg.sv
// Package for the RGB 5551 2x2 box downsampler.
// Pixel layout constants, pair-sum type, line RAM command type and helpers.
// No dependencies.
package rgbds_pkg;

  localparam int DEFAULT_MAX_OUT_WIDTH = 1024;
  localparam int HEIGHT_LIMIT          = 1024;
  localparam int CFG_W                 = 11;
  localparam int PIX_W                 = 16;
  localparam int CH_W                  = 5;
  localparam int SUM_W                 = 6;
  localparam int ROW_W                 = 10;

  // channel positions within a 5551 pixel
  localparam int R_LSB = 11;
  localparam int G_LSB = 6;
  localparam int B_LSB = 1;

  // configuration register indexes
  localparam logic REG_OUT_WIDTH  = 1'b0;
  localparam logic REG_OUT_HEIGHT = 1'b1;

  // horizontal pair sums, one line entry (18 bits, red on top)
  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } pair_sum_t;

  // line RAM access strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_cmd_t;

  // per-channel sum of two horizontally adjacent pixels
  function automatic pair_sum_t pair_add(input logic [PIX_W-1:0] a,
                                         input logic [PIX_W-1:0] b);
    pair_sum_t s;
    s.r = {1'b0, a[R_LSB +: CH_W]} + {1'b0, b[R_LSB +: CH_W]};
    s.g = {1'b0, a[G_LSB +: CH_W]} + {1'b0, b[G_LSB +: CH_W]};
    s.b = {1'b0, a[B_LSB +: CH_W]} + {1'b0, b[B_LSB +: CH_W]};
    return s;
  endfunction

  // four-sample average of one channel: (top pair + bottom pair) >> 2
  function automatic logic [CH_W-1:0] quad_avg(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SUM_W:2];
  endfunction

endpackage

>>> rtl/rgbds_line_ram.sv
// Line store of horizontal pair sums, one entry per output column.
// Single port, synchronous write, registered read. Uses rgbds_pkg.
module rgbds_line_ram
  import rgbds_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_OUT_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  ram_cmd_t      cmd,
  input  logic [AW-1:0] addr,
  input  pair_sum_t     wr_data,
  output pair_sum_t     rd_data
);

  pair_sum_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // read port, registered; data holds between reads
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> rtl/rgb5551_2x2_box_downsample.sv
// Top level of the RGB 5551 2x2 box-filter mipmap downsampler.
// Uses rgbds_pkg and rgbds_line_ram.
//
// Usage:
//   Source pixels enter on in_valid/in_stall/src_pixel in raster order,
//   2*out_width by 2*out_height. Each 2x2 block yields one beat on
//   out_valid/out_stall with out_pixel (alpha bit zero) and last_pixel,
//   which marks the final pixel of the image.
//   cfg_write/cfg_index/cfg_data set out_width (index 0) and out_height
//   (index 1) while the block is idle; zero counts as 1, and values above
//   the line depth or 1024 are clamped.
// Throughput: one source pixel per clock, sustained while in_stall stays low.
// Timing: the edge that accepts the second pixel of the bottom pair starts
//   the line RAM read and loads the read stage; the average is then
//   registered into the output register once the read stage can advance.
// Even source rows write pair sums to the line RAM; odd rows read them back
//   once, so the single RAM port is touched at most once per pixel pair.
// Reset clears the configuration, the position counters, the read-stage
//   valid and the output valid; the line RAM is not cleared and is always written before it is read.
// Receiver stall: the output register holds; one more result may wait in
//   the read stage, after which in_stall rises until the output drains.
module rgb5551_2x2_box_downsample
  import rgbds_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEFAULT_MAX_OUT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // source pixels
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] src_pixel,
  // downsampled pixels
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pixel,
  output logic             last_pixel
);

  localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  // last column / row index, held from config
  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;

  // position state
  logic             pixel_phase;
  logic             row_phase;
  logic [CW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;
  logic [PIX_W-1:0] held_pixel;

  // read stage
  logic             rd_valid;
  pair_sum_t        bot_sum;
  logic             rd_last;

  ram_cmd_t         ram_cmd;
  pair_sum_t        cur_sum;
  pair_sum_t        top_sum;

  logic             in_accept;
  logic             pair_done;
  logic             col_end;
  logic             advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= '0;
      row_last <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OUT_WIDTH: begin
          if (cfg_data == '0) begin
            col_last <= '0;
          end else if (32'(cfg_data) > 32'(MAX_OUT_WIDTH)) begin
            col_last <= CW'(MAX_OUT_WIDTH - 1);
          end else begin
            col_last <= CW'(cfg_data - 1'b1);
          end
        end
        REG_OUT_HEIGHT: begin
          if (cfg_data == '0) begin
            row_last <= '0;
          end else if (32'(cfg_data) > 32'(HEIGHT_LIMIT)) begin
            row_last <= ROW_W'(HEIGHT_LIMIT - 1);
          end else begin
            row_last <= ROW_W'(cfg_data - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // handshake and pair decode
  assign advance   = rd_valid && (!out_valid || !out_stall);
  assign in_stall  = rd_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign pair_done = in_accept && pixel_phase;
  assign col_end   = column_count >= col_last;
  assign cur_sum   = pair_add(held_pixel, src_pixel);

  assign ram_cmd.wr_en = pair_done && !row_phase;
  assign ram_cmd.rd_en = pair_done && row_phase;

  rgbds_line_ram #(
    .DEPTH (MAX_OUT_WIDTH),
    .AW    (CW)
  ) u_line_ram (
    .clk     (clk),
    .cmd     (ram_cmd),
    .addr    (column_count),
    .wr_data (cur_sum),
    .rd_data (top_sum)
  );

  // first pixel of each pair
  always_ff @(posedge clk) begin
    if (in_accept && !pixel_phase) begin
      held_pixel <= src_pixel;
    end
  end

  // column / row position
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_phase  <= 1'b0;
      row_phase    <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      pixel_phase <= !pixel_phase;
      if (pixel_phase) begin
        if (col_end) begin
          column_count <= '0;
          row_phase    <= !row_phase;
          if (row_phase) begin
            row_count <= (row_count >= row_last) ? '0 : row_count + 1'b1;
          end
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  // read stage: bottom pair sum waits for the line RAM data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (ram_cmd.rd_en) begin
      rd_valid <= 1'b1;
    end else if (advance) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_cmd.rd_en) begin
      bot_sum <= cur_sum;
      rd_last <= col_end && (row_count >= row_last);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pixel  <= {quad_avg(top_sum.r, bot_sum.r),
                     quad_avg(top_sum.g, bot_sum.g),
                     quad_avg(top_sum.b, bot_sum.b),
                     1'b0};
      last_pixel <= rd_last;
    end
  end

  // checks
  a_one_ram_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_cmd.wr_en && ram_cmd.rd_en))
    else $error("line RAM read and write in the same cycle");

  a_odd_pair_loads: assert property (@(posedge clk) disable iff (rst)
    pair_done && row_phase |=> rd_valid)
    else $error("bottom pair did not enter the read stage");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !advance |=> rd_valid && $stable(bot_sum) && $stable(top_sum))
    else $error("read stage lost data while blocked");

  a_no_even_write_when_blocked: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !advance |-> !ram_cmd.wr_en && !ram_cmd.rd_en)
    else $error("line RAM accessed while the read stage is blocked");

endmodule

>>> sim/mip_result_checker.sv
// Result checker for the 5551 2x2 box downsampler: mirrors the block's pixel
// pairing and line store, and compares every downsampled beat in order.
// Depends on rgbds_pkg.
module mip_result_checker
  import rgbds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [PIX_W-1:0] src_pixel,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [PIX_W-1:0] out_pixel,
  input  logic             last_pixel,
  output int               mismatches,
  output int               results_due
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } mip_pixel_t;

  // predicted block state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  pair_sum_t        line_sums [DEFAULT_MAX_OUT_WIDTH];
  logic [PIX_W-1:0] first_px;
  logic             pair_odd;
  logic [ROW_W-1:0] col_pos;
  logic             row_odd;
  logic [ROW_W-1:0] row_pos;

  mip_pixel_t due_pixels [$];
  int         beat_no;

  initial begin
    mismatches  = 0;
    results_due = 0;
    beat_no     = 0;
  end

  // zero counts as one, oversize settings saturate
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input int limit);
    if (v == '0) return CFG_W'(1);
    if (v > limit) return CFG_W'(limit);
    return v;
  endfunction

  // one source pixel: pair it up, store the top pair or emit the average
  task automatic absorb_source_pixel(input logic [PIX_W-1:0] px);
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] wl;
    logic [CFG_W-1:0] hl;
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
    logic [SUM_W:0]   rq;
    logic [SUM_W:0]   gq;
    logic [SUM_W:0]   bq;
    pair_sum_t        top;
    mip_pixel_t       res;
    w  = clamp_size(width_reg, DEFAULT_MAX_OUT_WIDTH);
    h  = clamp_size(height_reg, HEIGHT_LIMIT);
    wl = w - 1'b1;
    hl = h - 1'b1;
    if (!pair_odd) begin
      first_px = px;
      pair_odd = 1'b1;
    end else begin
      pair_odd = 1'b0;
      r = SUM_W'(first_px[R_LSB +: CH_W]) + SUM_W'(px[R_LSB +: CH_W]);
      g = SUM_W'(first_px[G_LSB +: CH_W]) + SUM_W'(px[G_LSB +: CH_W]);
      b = SUM_W'(first_px[B_LSB +: CH_W]) + SUM_W'(px[B_LSB +: CH_W]);
      if (!row_odd) begin
        line_sums[col_pos] = '{r: r, g: g, b: b};
      end else begin
        top = line_sums[col_pos];
        rq = {1'b0, r} + {1'b0, top.r};
        gq = {1'b0, g} + {1'b0, top.g};
        bq = {1'b0, b} + {1'b0, top.b};
        res.pixel = {rq[SUM_W:2], gq[SUM_W:2], bq[SUM_W:2], 1'b0};
        res.last  = ({1'b0, col_pos} >= wl) && ({1'b0, row_pos} >= hl);
        due_pixels.push_back(res);
      end
      // advance position; stale counts past the end wrap on this step
      if ({1'b0, col_pos} >= wl) begin
        col_pos = '0;
        if (row_odd) begin
          row_pos = ({1'b0, row_pos} >= hl) ? '0 : row_pos + 1'b1;
        end
        row_odd = ~row_odd;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = CFG_W'(1);
      height_reg = CFG_W'(1);
      pair_odd   = 1'b0;
      col_pos    = '0;
      row_odd    = 1'b0;
      row_pos    = '0;
      due_pixels.delete();
      results_due <= 0;
    end else begin
      // a beat at this edge still sees the old register values
      if (in_valid && !in_stall) begin
        absorb_source_pixel(src_pixel);
      end
      if (cfg_write) begin
        if (cfg_index == REG_OUT_WIDTH) begin
          width_reg = cfg_data;
        end else begin
          height_reg = cfg_data;
        end
      end
      // output beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_pixels.size() == 0) begin
          if (mismatches < 10) begin
            $display("downsampled beat %0d: none expected, got pixel %h last %b",
                     beat_no, out_pixel, last_pixel);
          end
          mismatches <= mismatches + 1;
        end else begin
          if (out_pixel !== due_pixels[0].pixel || last_pixel !== due_pixels[0].last) begin
            if (mismatches < 10) begin
              $display("downsampled beat %0d: expected pixel %h last %b, got pixel %h last %b",
                       beat_no, due_pixels[0].pixel, due_pixels[0].last,
                       out_pixel, last_pixel);
            end
            mismatches <= mismatches + 1;
          end
          void'(due_pixels.pop_front());
        end
        beat_no <= beat_no + 1;
      end
      results_due <= due_pixels.size();
    end
  end

endmodule

>>> sim/rgb5551_2x2_box_downsample_test.sv
// Testbench top for rgb5551_2x2_box_downsample: drives source images and
// register writes, throttles both channels and reports the verdict.
// Depends on rgbds_pkg, the block and mip_result_checker.
module rgb5551_2x2_box_downsample_test;
  import rgbds_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_PIXELS  = 330;

  logic             clk;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = REG_OUT_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] src_pixel = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_pixel;
  logic             last_pixel;

  int mismatches;
  int results_due;
  int send_gap_pct  = 6;
  int recv_idle_pct = 52;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  rgb5551_2x2_box_downsample dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .src_pixel  (src_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel  (out_pixel),
    .last_pixel (last_pixel)
  );

  mip_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .src_pixel   (src_pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel   (out_pixel),
    .last_pixel  (last_pixel),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rgb5551_2x2_box_downsample: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one source beat, with an optional random gap ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid  <= 1'b1;
    src_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random content with extra weight on all-ones and all-zero pixels
  task automatic send_random(input int count);
    repeat (count) begin
      case ($urandom_range(7))
        0:       send_pixel(16'hFFFF);
        1:       send_pixel(16'h0000);
        default: send_pixel(PIX_W'($urandom));
      endcase
    end
  endtask

  // stop offering and wait until every predicted pixel came out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int w;
    int h;
    int sent;
    int count;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // saturated block, then alpha-only against full color
    write_reg(REG_OUT_WIDTH, CFG_W'(1));
    write_reg(REG_OUT_HEIGHT, CFG_W'(1));
    repeat (4) send_pixel(16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'hFFFE);
    send_pixel(16'h0001);
    send_pixel(16'hFFFE);

    // width shrinks in the middle of a top row: column wraps early
    drain_results();
    write_reg(REG_OUT_WIDTH, CFG_W'(3));
    send_random(4);
    drain_results();
    write_reg(REG_OUT_WIDTH, CFG_W'(1));
    send_random(4);

    // height shrinks past the current row: image ends on the next row
    drain_results();
    write_reg(REG_OUT_HEIGHT, CFG_W'(2));
    send_random(4);
    drain_results();
    write_reg(REG_OUT_HEIGHT, CFG_W'(1));
    send_random(4);

    // random images under three throttling mixes
    w = 1;
    h = 1;
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      send_gap_pct  = (phase == 0) ? 6 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 6 : 0;
      if (phase == 2) begin
        // long receiver hold-off while a wide image streams in
        w = 16;
        h = 2;
        write_reg(REG_OUT_WIDTH, CFG_W'(w));
        write_reg(REG_OUT_HEIGHT, CFG_W'(h));
        hold_req <= hold_req + 1;
        send_random(4 * w * h);
      end
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(7))
            0:       w = 0;
            1:       w = 1;
            2:       w = $urandom_range(9, 24);
            default: w = $urandom_range(2, 8);
          endcase
          h = $urandom_range(0, 4);
          drain_results();
          write_reg(REG_OUT_WIDTH, CFG_W'(w));
          write_reg(REG_OUT_HEIGHT, CFG_W'(h));
        end
        count = 4 * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        send_random(count);
        sent += count;
      end
    end

    // oversize width: part of a top row, then shrink so the image closes
    drain_results();
    write_reg(REG_OUT_WIDTH, CFG_W'(2047));
    write_reg(REG_OUT_HEIGHT, CFG_W'(0));
    send_random(64);
    drain_results();
    write_reg(REG_OUT_WIDTH, CFG_W'(1));
    send_random(4);

    // oversize height: a few rows with no last flag, then shrink to close
    drain_results();
    write_reg(REG_OUT_WIDTH, CFG_W'(0));
    write_reg(REG_OUT_HEIGHT, CFG_W'(2047));
    send_random(32);
    drain_results();
    write_reg(REG_OUT_HEIGHT, CFG_W'(1));
    send_random(4);

    drain_results();
    if (mismatches == 0 && results_due == 0) begin
      $display("rgb5551_2x2_box_downsample: match");
    end else begin
      $display("rgb5551_2x2_box_downsample: mismatch");
    end
    $finish;
  end

endmodule
